// ===== rtl/core/stfs_ceg_pkg.sv =====
// Shared types and constants for the contiguous extent generator.
// Holds the transaction structs and the block geometry of the hashed package.
// No dependencies.
`timescale 1ns / 1ps

package stfs_ceg_pkg;

    // Width of the logical block number that is actually used on start.
    localparam int BLOCK_BITS = 24;

    localparam int START_W  = 24;
    localparam int BYTES_W  = 32;
    localparam int OFFSET_W = 38;
    localparam int SEG_W    = 20;
    localparam int LBLK_W   = 25;
    localparam int NBLK_W   = 8;

    localparam logic [LBLK_W-1:0]   GROUP_BLOCKS = LBLK_W'(170);
    localparam logic [LBLK_W-1:0]   LEVEL_BLOCKS = LBLK_W'(28900);
    localparam logic [OFFSET_W-1:0] DATA_BASE    = OFFSET_W'(32'hC000);
    localparam logic [OFFSET_W-1:0] BLOCK_BYTES  = OFFSET_W'(32'h1000);
    localparam logic [START_W-1:0]  BLOCK_MASK   = START_W'((64'd1 << BLOCK_BITS) - 64'd1);

    // Reciprocals for exact constant division of any 24-bit block number:
    // q = (b * RECIP) >> SHIFT.
    localparam int PROD_W        = 49;
    localparam int RECIP_SHIFT_G = 32;
    localparam int RECIP_SHIFT_L = 39;
    localparam logic [PROD_W-1:0] RECIP_GROUP = PROD_W'(25264515);
    localparam logic [PROD_W-1:0] RECIP_LEVEL = PROD_W'(19022693);
    localparam int QG_W = PROD_W - RECIP_SHIFT_G;
    localparam int QL_W = PROD_W - RECIP_SHIFT_L;

    typedef enum logic {
        OP_START = 1'b0,
        OP_NEXT  = 1'b1
    } opcode_t;

    typedef struct packed {
        logic                opcode;
        logic [START_W-1:0]  start_block;
        logic [BYTES_W-1:0]  file_bytes;
    } item_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] byte_offset;
        logic [SEG_W-1:0]    segment_bytes;
        logic                last;
        logic                error;
    } result_t;

    // Input register contents: the item with its start mapping already worked out.
    typedef struct packed {
        logic                opcode;
        logic [BYTES_W-1:0]  file_bytes;
        logic [LBLK_W-1:0]   first_block;
        logic [NBLK_W-1:0]   first_nblk;
        logic [LBLK_W-1:0]   first_bound;
        logic [OFFSET_W-1:0] first_offset;
    } stage_t;

endpackage

// ===== rtl/core/stfs_contiguous_extent_generator.sv =====
// Top level of the contiguous extent generator: start mapping, segment emission,
// transfer state and the configuration register.
// Depends on stfs_ceg_pkg.
// An accepted transaction is staged in the input register, and its result is registered
// in the result register. Throughput: one transaction per cycle while out_ready does not stall
// the result register; each register holds one item, and the start mapping is a pair
// of constant reciprocal multiplies ahead of the input register.
// Reset clears the pipeline valids, the transfer state and shift_reg.
`timescale 1ns / 1ps

module stfs_contiguous_extent_generator (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  stfs_ceg_pkg::item_t   in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output stfs_ceg_pkg::result_t out_item
);

    logic                                  shift_reg;
    logic                                  stage_valid_reg;
    stfs_ceg_pkg::stage_t                  stage_reg;
    stfs_ceg_pkg::stage_t                  stage_next;
    logic                                  out_valid_reg;
    stfs_ceg_pkg::result_t                 out_reg;
    stfs_ceg_pkg::result_t                 out_next;

    logic                                  active_reg;
    logic                                  active_next;
    logic [stfs_ceg_pkg::BYTES_W-1:0]      bytes_left_reg;
    logic [stfs_ceg_pkg::BYTES_W-1:0]      bytes_left_next;
    logic [stfs_ceg_pkg::OFFSET_W-1:0]     next_offset_reg;
    logic [stfs_ceg_pkg::OFFSET_W-1:0]     next_offset_next;
    logic [stfs_ceg_pkg::LBLK_W-1:0]       logical_block_reg;
    logic [stfs_ceg_pkg::LBLK_W-1:0]       logical_block_next;
    logic [stfs_ceg_pkg::LBLK_W-1:0]       level_boundary_reg;
    logic [stfs_ceg_pkg::LBLK_W-1:0]       level_boundary_next;

    logic                                  advance;

    // Start mapping signals
    logic [stfs_ceg_pkg::START_W-1:0]      blk;
    logic [stfs_ceg_pkg::PROD_W-1:0]       prod_g;
    logic [stfs_ceg_pkg::PROD_W-1:0]       prod_l;
    logic [stfs_ceg_pkg::QG_W-1:0]         q_group;
    logic [stfs_ceg_pkg::QL_W-1:0]         q_level;
    logic [stfs_ceg_pkg::START_W-1:0]      r_full;
    logic [stfs_ceg_pkg::LBLK_W-1:0]       blk_ext;
    logic [stfs_ceg_pkg::LBLK_W-1:0]       adj_group;
    logic [stfs_ceg_pkg::LBLK_W-1:0]       adj_level;
    logic [stfs_ceg_pkg::LBLK_W-1:0]       phys;

    assign cfg_ready = 1'b1;
    assign advance   = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !stage_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // Map the start block to its physical byte offset on the way in.
    always_comb
    begin
        blk     = in_item.start_block & stfs_ceg_pkg::BLOCK_MASK;
        blk_ext = stfs_ceg_pkg::LBLK_W'(blk);
        prod_g  = stfs_ceg_pkg::PROD_W'(blk) * stfs_ceg_pkg::RECIP_GROUP;
        prod_l  = stfs_ceg_pkg::PROD_W'(blk) * stfs_ceg_pkg::RECIP_LEVEL;
        q_group = prod_g[stfs_ceg_pkg::PROD_W-1:stfs_ceg_pkg::RECIP_SHIFT_G];
        q_level = prod_l[stfs_ceg_pkg::PROD_W-1:stfs_ceg_pkg::RECIP_SHIFT_L];
        r_full  = blk - stfs_ceg_pkg::START_W'(stfs_ceg_pkg::LBLK_W'(q_group)
                  * stfs_ceg_pkg::GROUP_BLOCKS);

        adj_group = '0;
        adj_level = '0;
        if (blk_ext >= stfs_ceg_pkg::GROUP_BLOCKS)
        begin
            adj_group = (stfs_ceg_pkg::LBLK_W'(q_group) + stfs_ceg_pkg::LBLK_W'(1))
                        << shift_reg;
        end
        if (blk_ext >= stfs_ceg_pkg::LEVEL_BLOCKS)
        begin
            adj_level = (stfs_ceg_pkg::LBLK_W'(q_level) + stfs_ceg_pkg::LBLK_W'(1))
                        << shift_reg;
        end
        phys = blk_ext + adj_group + adj_level;

        stage_next.opcode      = in_item.opcode;
        stage_next.file_bytes  = in_item.file_bytes;
        stage_next.first_block = blk_ext;
        stage_next.first_nblk  = stfs_ceg_pkg::NBLK_W'(stfs_ceg_pkg::GROUP_BLOCKS)
                                 - r_full[stfs_ceg_pkg::NBLK_W-1:0];
        stage_next.first_bound = stfs_ceg_pkg::LBLK_W'(
                                     (stfs_ceg_pkg::LBLK_W'(q_level) + stfs_ceg_pkg::LBLK_W'(1))
                                     * stfs_ceg_pkg::LEVEL_BLOCKS);
        stage_next.first_offset = stfs_ceg_pkg::DATA_BASE
                                  + (stfs_ceg_pkg::OFFSET_W'(phys) << 12);
    end

    // Emit one segment, or an error result when there is none, from the staged item and the transfer state.
    always_comb
    begin
        logic [stfs_ceg_pkg::BYTES_W-1:0]  bytes;
        logic [stfs_ceg_pkg::LBLK_W-1:0]   lb;
        logic [stfs_ceg_pkg::LBLK_W-1:0]   bound;
        logic [stfs_ceg_pkg::OFFSET_W-1:0] off;
        logic [stfs_ceg_pkg::NBLK_W-1:0]   nblk;
        logic [stfs_ceg_pkg::SEG_W-1:0]    len_full;
        logic [stfs_ceg_pkg::SEG_W-1:0]    len;
        logic [stfs_ceg_pkg::BYTES_W-1:0]  remain;
        logic [stfs_ceg_pkg::LBLK_W-1:0]   lb_new;
        logic [stfs_ceg_pkg::OFFSET_W-1:0] skip;
        logic [stfs_ceg_pkg::OFFSET_W-1:0] off_new;
        logic                              do_emit;

        active_next         = active_reg;
        bytes_left_next     = bytes_left_reg;
        next_offset_next    = next_offset_reg;
        logical_block_next  = logical_block_reg;
        level_boundary_next = level_boundary_reg;

        out_next.byte_offset   = '0;
        out_next.segment_bytes = '0;
        out_next.last          = 1'b0;
        out_next.error         = 1'b1;

        skip = shift_reg ? (stfs_ceg_pkg::BLOCK_BYTES << 1) : stfs_ceg_pkg::BLOCK_BYTES;

        do_emit = 1'b0;
        bytes   = bytes_left_reg;
        lb      = logical_block_reg;
        bound   = level_boundary_reg;
        off     = next_offset_reg;
        nblk    = stfs_ceg_pkg::NBLK_W'(stfs_ceg_pkg::GROUP_BLOCKS);

        if (stage_reg.opcode == stfs_ceg_pkg::OP_START)
        begin
            if (stage_reg.file_bytes == '0)
            begin
                // Drop any transfer in flight.
                active_next = 1'b0;
            end
            else
            begin
                do_emit = 1'b1;
                bytes   = stage_reg.file_bytes;
                lb      = stage_reg.first_block;
                bound   = stage_reg.first_bound;
                off     = stage_reg.first_offset;
                nblk    = stage_reg.first_nblk;
            end
        end
        else if (active_reg)
        begin
            do_emit = 1'b1;
        end

        len_full = {nblk, 12'h000};
        if (stfs_ceg_pkg::BYTES_W'(len_full) > bytes)
        begin
            len = bytes[stfs_ceg_pkg::SEG_W-1:0];
        end
        else
        begin
            len = len_full;
        end
        remain  = bytes - stfs_ceg_pkg::BYTES_W'(len);
        lb_new  = lb + stfs_ceg_pkg::LBLK_W'(nblk);
        off_new = off + stfs_ceg_pkg::OFFSET_W'(len) + skip;

        if (do_emit)
        begin
            out_next.byte_offset   = off;
            out_next.segment_bytes = len;
            out_next.last          = (remain == '0);
            out_next.error         = 1'b0;
            bytes_left_next        = remain;
            if (remain == '0)
            begin
                active_next = 1'b0;
            end
            else
            begin
                active_next         = 1'b1;
                logical_block_next  = lb_new;
                level_boundary_next = bound;
                next_offset_next    = off_new;
                // Level boundary: skip a second table.
                if (lb_new == bound)
                begin
                    next_offset_next    = off_new + skip;
                    level_boundary_next = bound + stfs_ceg_pkg::LEVEL_BLOCKS;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg          <= 1'b0;
            stage_valid_reg    <= 1'b0;
            out_valid_reg      <= 1'b0;
            active_reg         <= 1'b0;
            bytes_left_reg     <= '0;
            next_offset_reg    <= '0;
            logical_block_reg  <= '0;
            level_boundary_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                shift_reg <= cfg_data;
            end
            if (in_ready)
            begin
                stage_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg      <= 1'b1;
                active_reg         <= active_next;
                bytes_left_reg     <= bytes_left_next;
                next_offset_reg    <= next_offset_next;
                logical_block_reg  <= logical_block_next;
                level_boundary_reg <= level_boundary_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_reg <= stage_next;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTH
    a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.error |->
            out_reg.byte_offset == '0 && out_reg.segment_bytes == '0 && !out_reg.last)
        else $error("error result carries nonzero fields");

    a_segment_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.error |-> out_reg.segment_bytes != '0)
        else $error("good result with empty segment");

    a_last_clears_active: assert property (@(posedge clk) disable iff (!rst_n)
        advance && out_next.last |=> !active_reg)
        else $error("transfer still active after last segment");

    a_active_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> bytes_left_reg != '0)
        else $error("active transfer with no bytes left");

    a_stage_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !advance |-> !in_ready)
        else $error("input register open while holding a stalled item");
`endif

endmodule

// ===== dv/stfs_ceg_checker.sv =====
// Checker for the contiguous extent generator: watches the config, item and result channels,
// predicts every segment from the accepted transactions and compares field by field.
// Depends on stfs_ceg_pkg.
`timescale 1ns / 1ps

module stfs_ceg_checker
    import stfs_ceg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cfg_valid,
    input  logic    cfg_ready,
    input  logic    cfg_data,
    input  logic    in_valid,
    input  logic    in_ready,
    input  item_t   in_item,
    input  logic    out_valid,
    input  logic    out_ready,
    input  result_t out_item,
    output int      mismatches,
    output int      pending,
    output int      segments_checked,
    output int      error_results,
    output int      last_results
);

    result_t segment_q[$];

    // Shadow of the spacing register and the transfer state
    logic                spacing_shift;
    logic                xfer_active;
    logic [BYTES_W-1:0]  bytes_remaining;
    logic [OFFSET_W-1:0] resume_offset;
    logic [LBLK_W-1:0]   next_block;
    logic [LBLK_W-1:0]   level_mark;

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Cut one segment of up to nblk blocks at offset seg_at, then advance past the hash table.
    task automatic cut_segment(logic [OFFSET_W-1:0] seg_at, logic [LBLK_W-1:0] nblk,
                               output result_t seg);
        logic [63:0]         len;
        logic [OFFSET_W-1:0] skip;
        len  = 64'(nblk) * 64'(BLOCK_BYTES);
        skip = BLOCK_BYTES << spacing_shift;
        if (len > 64'(bytes_remaining))
            len = 64'(bytes_remaining);
        bytes_remaining = bytes_remaining - len[BYTES_W-1:0];
        seg               = '0;
        seg.byte_offset   = seg_at;
        seg.segment_bytes = len[SEG_W-1:0];
        seg.last          = (bytes_remaining == '0);
        if (bytes_remaining == '0)
        begin
            xfer_active = 1'b0;
        end
        else
        begin
            xfer_active   = 1'b1;
            next_block    = next_block + nblk;
            resume_offset = seg_at + len[OFFSET_W-1:0] + skip;
            // Crossing into a new level: skip the second-level table too
            if (next_block == level_mark)
            begin
                resume_offset = resume_offset + skip;
                level_mark    = level_mark + LEVEL_BLOCKS;
            end
        end
    endtask

    task automatic predict_segment(item_t it, output result_t seg);
        logic [START_W-1:0] blk;
        longint unsigned    b;
        longint unsigned    adj;
        seg       = '0;
        seg.error = 1'b1;
        if (opcode_t'(it.opcode) == OP_START)
        begin
            if (it.file_bytes == '0)
            begin
                xfer_active = 1'b0;
            end
            else
            begin
                blk = it.start_block & BLOCK_MASK;
                b   = blk;
                adj = 0;
                if (b >= GROUP_BLOCKS)
                begin
                    adj += ((b / GROUP_BLOCKS) + 1) << spacing_shift;
                    if (b >= LEVEL_BLOCKS)
                        adj += ((b / LEVEL_BLOCKS) + 1) << spacing_shift;
                end
                bytes_remaining = it.file_bytes;
                next_block      = LBLK_W'(b);
                level_mark      = LBLK_W'(((b / LEVEL_BLOCKS) + 1) * LEVEL_BLOCKS);
                cut_segment(OFFSET_W'(DATA_BASE + (b + adj) * BLOCK_BYTES),
                            LBLK_W'(GROUP_BLOCKS - (b % GROUP_BLOCKS)), seg);
            end
        end
        else if (xfer_active)
        begin
            cut_segment(resume_offset, GROUP_BLOCKS, seg);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t seg;
        result_t want;
        if (!rst_n)
        begin
            segment_q.delete();
            spacing_shift    = 1'b0;
            xfer_active      = 1'b0;
            bytes_remaining  = '0;
            resume_offset    = '0;
            next_block       = '0;
            level_mark       = '0;
            mismatches       = 0;
            pending          = 0;
            segments_checked = 0;
            error_results    = 0;
            last_results     = 0;
        end
        else
        begin
            // Queue first so a result in the same cycle still finds its expectation
            if (in_valid && in_ready)
            begin
                predict_segment(in_item, seg);
                segment_q = {segment_q, seg};
            end
            if (out_valid && out_ready)
            begin
                if (segment_q.size() == 0)
                begin
                    report("result with nothing expected", 64'(out_item), 64'd0);
                end
                else
                begin
                    want = segment_q.pop_front();
                    segments_checked++;
                    if (want.error)
                        error_results++;
                    if (want.last)
                        last_results++;
                    if (out_item.byte_offset !== want.byte_offset)
                        report("byte_offset", 64'(out_item.byte_offset), 64'(want.byte_offset));
                    if (out_item.segment_bytes !== want.segment_bytes)
                        report("segment_bytes", 64'(out_item.segment_bytes),
                               64'(want.segment_bytes));
                    if (out_item.last !== want.last)
                        report("last", 64'(out_item.last), 64'(want.last));
                    if (out_item.error !== want.error)
                        report("error", 64'(out_item.error), 64'(want.error));
                end
            end
            if (cfg_valid && cfg_ready)
                spacing_shift = cfg_data;
            pending = segment_q.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
// Top of the extent generator testbench: clock, reset, stimulus and the verdict.
// Instantiates stfs_contiguous_extent_generator and stfs_ceg_checker; depends on stfs_ceg_pkg.
`timescale 1ns / 1ps

module tb;
    import stfs_ceg_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int GROUP_BYTES = 170 * 4096;
    localparam int PHASE_ITEMS = 380;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    logic    cfg_data  = 1'b0;
    logic    in_valid  = 1'b0;
    logic    in_ready;
    item_t   in_item   = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    result_t out_item;

    int mismatches;
    int pending;
    int segments_checked;
    int error_results;
    int last_results;

    int items_sent   = 0;
    int cycles       = 0;
    bit send_steady  = 1'b0;
    bit drain_steady = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    stfs_contiguous_extent_generator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    stfs_ceg_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .in_item          (in_item),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_item         (out_item),
        .mismatches       (mismatches),
        .pending          (pending),
        .segments_checked (segments_checked),
        .error_results    (error_results),
        .last_results     (last_results)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d segments still expected", cycles, pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: random stall before each segment, with stretches of no stall
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                drain_steady = !drain_steady;
            stall = drain_steady ? 0 : $urandom_range(0, 14);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(negedge clk); while (!out_valid);
            @(posedge clk);
        end
    end

    task automatic send(opcode_t op, logic [START_W-1:0] blk, logic [BYTES_W-1:0] nbytes);
        item_t it;
        int    gap;
        it.opcode      = op;
        it.start_block = blk;
        it.file_bytes  = nbytes;
        if ($urandom_range(0, 39) == 0)
            send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        items_sent++;
    endtask

    // Unused fields of a next request carry noise
    task automatic send_next();
        send(OP_NEXT, START_W'($urandom), $urandom);
    endtask

    // Hold the sender until every expected segment is back, then let the pipe drain
    task automatic drain_all();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_spacing(logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int nexts_to_finish(logic [START_W-1:0] blk, logic [BYTES_W-1:0] nbytes);
        longint unsigned b;
        longint unsigned first_len;
        b         = blk;
        first_len = (170 - (b % 170)) * 4096;
        if (nbytes <= first_len)
            return 0;
        return int'((nbytes - first_len + GROUP_BYTES - 1) / GROUP_BYTES);
    endfunction

    // One file: a start and its next requests, sometimes cut short or run past the end
    task automatic run_file();
        logic [START_W-1:0] blk;
        logic [BYTES_W-1:0] nbytes;
        int                 need;
        int                 n;
        case ($urandom_range(0, 9))
            0, 1, 2: blk = START_W'($urandom);
            3, 4:    blk = START_W'($urandom_range(1, 580) * 28900 - $urandom_range(1, 400));
            5:       blk = START_W'($urandom_range(0, 98000) * 170 +
                                    ($urandom_range(0, 1) ? 0 : 169));
            6:       blk = 24'hFF_FFFF - START_W'($urandom_range(0, 2000));
            default: blk = START_W'($urandom_range(0, 1000));
        endcase
        case ($urandom_range(0, 9))
            0:       nbytes = $urandom;
            1:       nbytes = $urandom_range(1, 4096);
            2:       nbytes = BYTES_W'($urandom_range(1, 12) * GROUP_BYTES);
            3:       nbytes = BYTES_W'($urandom_range(1, 3000)) << 12;
            default: nbytes = $urandom_range(1, 6 * GROUP_BYTES);
        endcase
        send(OP_START, blk, nbytes);
        need = nexts_to_finish(blk, nbytes);
        n    = need;
        if (n > 12 || $urandom_range(0, 7) == 0)
            n = $urandom_range(0, (n > 12) ? 12 : n);
        repeat (n) send_next();
        if (n == need && $urandom_range(0, 3) == 0)
            send_next();
    endtask

    task automatic random_phase(int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            case ($urandom_range(0, 19))
                0:       send_next();
                1:       send(OP_START, START_W'($urandom), '0);
                default: run_file();
            endcase
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, spacing shift at its reset value
        send_next();                                // nothing active after reset
        send(OP_START, 24'd1234, 32'd0);            // zero size
        send_next();                                // still idle after a zero size
        send(OP_START, 24'd0, 32'd1);               // single byte
        send(OP_START, 24'd169, 32'hFFFF_FFFF);     // one-block first segment, largest size
        send_next();
        send_next();
        send(OP_START, 24'd28899, 32'hFFFF_FFFF);   // first segment ends on a level boundary
        send_next();
        send(OP_START, 24'hFF_FFFF, 32'h0800_0000); // highest block number
        send_next();
        send_next();
        send(OP_START, 24'd340, 32'(GROUP_BYTES));  // exactly one full group
        send_next();                                // past the end of the file
        send(OP_START, 24'd500, 32'd5000);          // short tail inside the first group
        send(OP_START, 24'd170, 32'(2 * GROUP_BYTES + 1));
        send_next();
        send_next();
        send(OP_START, 24'd28730, 32'hFFFF_FFFF);   // full group that reaches the level boundary
        send_next();
        send(OP_START, 24'd7, 32'h00FF_FFFF);       // dropped by the next start
        send(OP_START, 24'hAB_CDEF, 32'hFFFF_F000);
        send_next();
        drain_all();

        write_spacing(1'b1);
        random_phase(PHASE_ITEMS);
        drain_all();
        write_spacing(1'b0);
        random_phase(PHASE_ITEMS);
        drain_all();
        write_spacing(1'b1);
        random_phase(PHASE_ITEMS);

        drain_all();
        repeat (10) @(posedge clk);
        $display("covered %0d transactions at spacing shift 0 and 1, %0d segments checked",
                 items_sent, segments_checked);
        $display("of those %0d were errors and %0d closed a file", error_results, last_results);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/stfs_ceg_pkg.sv
rtl/core/stfs_contiguous_extent_generator.sv
dv/stfs_ceg_checker.sv
dv/tb.sv
